[hdl/fwt_pkg.sv]
// types and constants shared by the futex waiter table modules
`default_nettype none
package fwt_pkg;
	localparam logic [31:0] WAKE_LIMIT = 32'd32;
	localparam logic [31:0] WAKE_ALL = 32'h7fffffff;
	localparam logic [47:0] ALIGN_MASK = 48'h3;

	typedef enum logic [1:0] {
		OP_WAIT = 2'd0,
		OP_WAKE = 2'd1,
		OP_REQUEUE = 2'd2,
		OP_WITHDRAW = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_MISALIGNED = 3'd1,
		ST_FAULT = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_FULL = 3'd4,
		ST_WITHDRAWN = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		K_REPORT,
		K_WAIT,
		K_WAKE,
		K_WITHDRAW
	} kind_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_WAKE
	} fsm_t;

	typedef struct packed {
		logic [15:0] proc;
		logic [47:0] addr;
		logic [7:0] waiter;
	} entry_t;

	typedef struct packed {
		kind_t kind;
		status_t status;
		entry_t key;
		logic [5:0] eff;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic valid;
		logic [7:0] who;
		logic [5:0] total;
		logic last;
	} result_t;
endpackage
`default_nettype wire

[hdl/futex_waiter_table.sv]
// top level of the futex waiter table
// Requests enter through a two-beat command queue; each wait, withdraw or refused request
// gives one result beat, and a wake or requeue gives one beat per woken waiter (or a single
// plain beat when none is woken), one per cycle while the result queue has room, as the table
// removes the newest match and closes the gap. The pace is set by the single match-and-remove
// step on the table; results wait in a two-beat output queue. After reset the table is empty
// and ready at once.
`default_nettype none
module futex_waiter_table import fwt_pkg::*; #(
	parameter int WAITER_SLOTS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [1:0] opcode,
	input wire logic [7:0] waiter_id,
	input wire logic [15:0] process_id,
	input wire logic [47:0] word_address,
	input wire logic [31:0] expected_value,
	input wire logic [31:0] current_value,
	input wire logic access_fault,
	input wire logic signed [31:0] wake_count,
	input wire logic signed [31:0] requeue_count,
	output logic empty,
	input wire logic pop,
	output logic [2:0] status,
	output logic waiter_valid,
	output logic [7:0] woken_waiter,
	output logic [5:0] woken_total,
	output logic last
);
	cmd_t cmd_in, cmd_out;
	result_t res_in, res_out;
	logic cmd_empty, cmd_pop, res_full, res_push;

	fwt_front u_front (
		.opcode, .waiter_id, .process_id, .word_address, .expected_value,
		.current_value, .access_fault, .wake_count, .requeue_count, .cmd(cmd_in)
	);

	fwt_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
		.clk, .arst_n, .wr_en(push), .wr_data(cmd_in), .full,
		.rd_en(cmd_pop), .rd_data(cmd_out), .empty(cmd_empty)
	);

	fwt_back #(.SLOTS(WAITER_SLOTS)) u_back (
		.clk, .arst_n, .cmd_empty, .cmd(cmd_out), .cmd_pop,
		.res_full, .res_push, .res(res_in)
	);

	fwt_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
		.clk, .arst_n, .wr_en(res_push), .wr_data(res_in), .full(res_full),
		.rd_en(pop), .rd_data(res_out), .empty
	);

	assign status = res_out.status;
	assign waiter_valid = res_out.valid;
	assign woken_waiter = res_out.who;
	assign woken_total = res_out.total;
	assign last = res_out.last;
endmodule
`default_nettype wire

[hdl/fwt_fifo.sv]
// small first-in first-out queue
`default_nettype none
module fwt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [WIDTH-1:0] wr_data,
	output logic full,
	input wire logic rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : AW'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : AW'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= (AW+1)'(cnt_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= (AW+1)'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end
endmodule
`default_nettype wire

[hdl/fwt_front.sv]
// front end: checks and classifies each request into a table command
`default_nettype none
module fwt_front import fwt_pkg::*; (
	input wire logic [1:0] opcode,
	input wire logic [7:0] waiter_id,
	input wire logic [15:0] process_id,
	input wire logic [47:0] word_address,
	input wire logic [31:0] expected_value,
	input wire logic [31:0] current_value,
	input wire logic access_fault,
	input wire logic signed [31:0] wake_count,
	input wire logic signed [31:0] requeue_count,
	output cmd_t cmd
);
	logic misaligned;
	logic [30:0] a, b;
	logic [31:0] sum, clamped, wake_n, cnt;

	assign misaligned = |(word_address & ALIGN_MASK);
	assign a = wake_count[31] ? '0 : wake_count[30:0];
	assign b = requeue_count[31] ? '0 : requeue_count[30:0];
	assign sum = {1'b0, a} + {1'b0, b};
	assign clamped = (sum > WAKE_ALL) ? WAKE_ALL : sum;
	assign wake_n = wake_count[31] ? WAKE_ALL : $unsigned(wake_count);

	always_comb begin
		cnt = (opcode_t'(opcode) == OP_REQUEUE) ? clamped : wake_n;
		cmd.key.proc = process_id;
		cmd.key.addr = word_address;
		cmd.key.waiter = waiter_id;
		cmd.eff = (cnt > WAKE_LIMIT) ? WAKE_LIMIT[5:0] : cnt[5:0];
		cmd.kind = K_REPORT;
		cmd.status = ST_OK;
		unique case (opcode_t'(opcode))
			OP_WITHDRAW: begin
				cmd.kind = K_WITHDRAW;
			end
			OP_WAIT: begin
				priority if (misaligned) cmd.status = ST_MISALIGNED;
				else if (access_fault) cmd.status = ST_FAULT;
				else if (current_value != expected_value) cmd.status = ST_MISMATCH;
				else cmd.kind = K_WAIT;
			end
			default: begin
				priority if (misaligned) cmd.status = ST_MISALIGNED;
				else if (access_fault) cmd.status = ST_FAULT;
				else cmd.kind = K_WAKE;
			end
		endcase
	end
endmodule
`default_nettype wire

[hdl/fwt_back.sv]
// back end: waiter table, insert, withdraw and one wake per cycle while the result queue has room
`default_nettype none
module fwt_back import fwt_pkg::*; #(
	parameter int SLOTS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_empty,
	input cmd_t cmd,
	output logic cmd_pop,
	input wire logic res_full,
	output logic res_push,
	output result_t res
);
	entry_t tbl_q [SLOTS];
	entry_t up_e [SLOTS];
	logic [SLOTS-1:0] vld_q, up_v, match, first, ge;
	logic [5:0] k_q, k, k_inc;
	logic [7:0] who;
	logic any, more, go, do_insert, do_remove, wake_cont, fin;
	fsm_t state_q, state_d;

	for (genvar j = 0; j < SLOTS; j++) begin : g_slot
		assign match[j] = vld_q[j] && ((cmd.kind == K_WITHDRAW) ?
			(tbl_q[j].waiter == cmd.key.waiter) :
			(tbl_q[j].proc == cmd.key.proc && tbl_q[j].addr == cmd.key.addr));
		if (j == SLOTS-1) begin : g_top
			assign up_e[j] = tbl_q[j];
			assign up_v[j] = 1'b0;
		end else begin : g_mid
			assign up_e[j] = tbl_q[j+1];
			assign up_v[j] = vld_q[j+1];
		end
	end

	assign first = match & (~match + 1'b1);
	assign ge = ~(first - 1'b1);
	assign any = |match;
	assign more = |(match & ~first);
	assign go = !cmd_empty && !res_full;
	assign k = (state_q == FSM_WAKE) ? k_q : '0;
	assign k_inc = 6'(k + 1'b1);

	always_comb begin
		who = '0;
		for (int j = 0; j < SLOTS; j++) begin
			if (first[j]) who = who | tbl_q[j].waiter;
		end
	end

	always_comb begin
		res = '{status: ST_OK, valid: 1'b0, who: '0, total: '0, last: 1'b1};
		res_push = go;
		cmd_pop = go;
		do_insert = 1'b0;
		do_remove = 1'b0;
		wake_cont = 1'b0;
		fin = 1'b1;
		unique case (cmd.kind)
			K_REPORT: begin
				res.status = cmd.status;
			end
			K_WAIT: begin
				if (vld_q[SLOTS-1]) res.status = ST_FULL;
				else do_insert = go;
			end
			K_WITHDRAW: begin
				if (any) begin
					res.status = ST_WITHDRAWN;
					do_remove = go;
				end
			end
			K_WAKE: begin
				if (k != '0 || (cmd.eff != '0 && any)) begin
					fin = (k_inc == cmd.eff) || !more;
					res.valid = 1'b1;
					res.who = who;
					res.total = k_inc;
					res.last = fin;
					do_remove = go;
					cmd_pop = go && fin;
					wake_cont = go && !fin;
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (wake_cont) state_d = FSM_WAKE;
			FSM_WAKE: if (go && fin) state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			k_q <= '0;
			vld_q <= '0;
		end else begin
			state_q <= state_d;
			// hold the running count while the result side stalls
			if (wake_cont) begin
				k_q <= k_inc;
			end else if (go) begin
				k_q <= '0;
			end
			if (do_insert) begin
				vld_q <= {vld_q[SLOTS-2:0], 1'b1};
			end else if (do_remove) begin
				for (int j = 0; j < SLOTS; j++) begin
					if (ge[j]) vld_q[j] <= up_v[j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			tbl_q[0] <= cmd.key;
			for (int j = 1; j < SLOTS; j++) tbl_q[j] <= tbl_q[j-1];
		end else if (do_remove) begin
			for (int j = 0; j < SLOTS; j++) begin
				if (ge[j]) tbl_q[j] <= up_e[j];
			end
		end
	end
endmodule
`default_nettype wire

[hdl/fwt_checker.sv]
// port-level checks on the futex waiter table result beats
`default_nettype none
module fwt_checker import fwt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire logic pop,
	input wire logic [2:0] status,
	input wire logic waiter_valid,
	input wire logic [7:0] woken_waiter,
	input wire logic [5:0] woken_total,
	input wire logic last
);
	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !waiter_valid |-> last && woken_total == '0 && woken_waiter == '0)
		else $error("plain beat carries waiter data");
	a_woken: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && waiter_valid |-> status == ST_OK && woken_total != '0 &&
			woken_total <= 6'd32)
		else $error("woken beat malformed");
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && waiter_valid && woken_total > 6'd1 |-> !last || woken_total <= 6'd32)
		else $error("woken total out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status) && $stable(woken_total) && $stable(last))
		else $error("stalled beat changed");
endmodule

bind futex_waiter_table fwt_checker u_chk (.*);
`default_nettype wire
